[rtl/mdff_pkg.sv]
// Shared types and constants for the mesh duplicate filter and forwarder.
`timescale 1ns / 1ps

package mdff_pkg;

    localparam int SRC_W   = 8;
    localparam int SEQ_W   = 16;
    localparam int TTL_W   = 8;
    localparam int ENTRY_W = SRC_W + SEQ_W;
    localparam int ACT_W   = 3;

    // register map: index taken from paddr[2]
    localparam logic REG_MY_ID = 1'b0;

    typedef enum logic [ACT_W-1:0] {
        ACT_OWN         = 3'd0,
        ACT_DUP         = 3'd1,
        ACT_TTL_EXPIRED = 3'd2,
        ACT_FORWARD     = 3'd3,
        ACT_DEFERRED    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RECORD,
        ST_DONE
    } state_t;

endpackage

[rtl/mdff_ram.sv]
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps

module mdff_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/mesh_duplicate_filter_forwarder.sv]
// Top level of the mesh duplicate filter and forwarder.
`timescale 1ns / 1ps

// Takes one received packet header per input beat and returns one verdict
// beat: own packet dropped, duplicate, ttl expired, forward (with ttl - 1)
// or deferred. A ring of the last SEEN_DEPTH (src, seq) pairs lives in a
// RAM with one write and one read port and is scanned one entry per cycle
// by one shared 24-bit compare. A foreign packet goes through accept, the
// scan with its registered read, record and hand-off; a duplicate leaves
// the scan early, and an own packet skips the scan. The input is not ready
// while an item is in work; the output register lets the next header be
// taken while a verdict waits.
// Ring entries carry valid bits cleared at reset; an entry never written
// reads as (0,0), so the pair (0,0) counts as seen after reset. No
// clearing pass is needed. my_id is written over APB at byte address 0
// and must only change while the block is idle.
module mesh_duplicate_filter_forwarder #(
    parameter int SEEN_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    // header in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [7:0] src, [23:8] seq, [31:24] ttl
    input  logic        s_axis_tuser,   // [0] forward_allowed

    // verdict out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] new_ttl
    output logic [2:0]  m_axis_tuser,   // [2:0] action

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(SEEN_DEPTH);
    localparam int CW = $clog2(SEEN_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(SEEN_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(SEEN_DEPTH - 1);

    // ---------------- configuration ----------------
    logic [mdff_pkg::SRC_W-1:0] my_id_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_id_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == mdff_pkg::REG_MY_ID))
        begin
            my_id_reg <= pwdata[mdff_pkg::SRC_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == mdff_pkg::REG_MY_ID)
        begin
            prdata = {{(32 - mdff_pkg::SRC_W){1'b0}}, my_id_reg};
        end
    end

    // ---------------- state ----------------
    mdff_pkg::state_t  state_reg, state_next;

    logic [AW-1:0]             wp_reg, wp_next;
    logic [SEEN_DEPTH-1:0]     valid_reg, valid_next;
    logic [CW-1:0]             scan_cnt_reg, scan_cnt_next;
    logic                      rd_pend_reg;
    logic                      valid_q_reg;
    logic                      out_valid_reg, out_valid_next;

    logic [mdff_pkg::SRC_W-1:0] src_reg, src_next;
    logic [mdff_pkg::SEQ_W-1:0] seq_reg, seq_next;
    logic [mdff_pkg::TTL_W-1:0] ttl_reg, ttl_next;
    logic                       fwd_ok_reg, fwd_ok_next;
    logic                       own_reg, own_next;
    mdff_pkg::action_t          res_action_reg, res_action_next;
    logic [mdff_pkg::TTL_W-1:0] res_ttl_reg, res_ttl_next;
    mdff_pkg::action_t          out_action_reg, out_action_next;
    logic [mdff_pkg::TTL_W-1:0] out_ttl_reg, out_ttl_next;

    // control strobes
    logic                         in_acc;
    logic                         ram_re;
    logic                         ram_we;
    logic                         out_load;
    logic [AW-1:0]                ram_raddr;
    logic [mdff_pkg::ENTRY_W-1:0] ram_rdata;
    logic [mdff_pkg::ENTRY_W-1:0] entry;
    logic                         hit_now;
    logic                         scan_end;
    logic                         in_own;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_own    = (s_axis_tdata[7:0] == my_id_reg);
    assign ram_raddr = scan_cnt_reg[AW-1:0];

    // the shared compare: one ring entry per cycle against the held key
    assign entry    = valid_q_reg ? ram_rdata : '0;
    assign hit_now  = rd_pend_reg && (entry == {src_reg, seq_reg});
    assign scan_end = (scan_cnt_reg == DEPTH_C);

    // ring storage
    mdff_ram #(
        .WIDTH (mdff_pkg::ENTRY_W),
        .DEPTH (SEEN_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata ({src_reg, seq_reg}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mdff_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = in_own ? mdff_pkg::ST_RECORD : mdff_pkg::ST_SCAN;
                end
            end
            mdff_pkg::ST_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = mdff_pkg::ST_DONE;
                end
                else if (scan_end)
                begin
                    state_next = mdff_pkg::ST_RECORD;
                end
            end
            mdff_pkg::ST_RECORD:
            begin
                state_next = mdff_pkg::ST_DONE;
            end
            mdff_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = mdff_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mdff_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            mdff_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            mdff_pkg::ST_SCAN:
            begin
                ram_re = !scan_end;
            end
            mdff_pkg::ST_RECORD:
            begin
                ram_we = 1'b1;
            end
            mdff_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // ---------------- datapath next values ----------------
    always_comb
    begin
        src_next        = src_reg;
        seq_next        = seq_reg;
        ttl_next        = ttl_reg;
        fwd_ok_next     = fwd_ok_reg;
        own_next        = own_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_action_next = res_action_reg;
        res_ttl_next    = res_ttl_reg;
        wp_next         = wp_reg;
        valid_next      = valid_reg;
        out_valid_next  = out_valid_reg;
        out_action_next = out_action_reg;
        out_ttl_next    = out_ttl_reg;

        if (in_acc)
        begin
            src_next      = s_axis_tdata[7:0];
            seq_next      = s_axis_tdata[23:8];
            ttl_next      = s_axis_tdata[31:24];
            fwd_ok_next   = s_axis_tuser;
            own_next      = in_own;
            scan_cnt_next = '0;
        end

        if (ram_re)
        begin
            scan_cnt_next = scan_cnt_reg + CW'(1);
        end

        if ((state_reg == mdff_pkg::ST_SCAN) && hit_now)
        begin
            res_action_next = mdff_pkg::ACT_DUP;
            res_ttl_next    = '0;
        end

        if (ram_we)
        begin
            valid_next[wp_reg] = 1'b1;
            wp_next            = (wp_reg == LAST_IDX) ? '0 : wp_reg + AW'(1);
            res_ttl_next       = '0;
            if (own_reg)
            begin
                res_action_next = mdff_pkg::ACT_OWN;
            end
            else if (ttl_reg == '0)
            begin
                res_action_next = mdff_pkg::ACT_TTL_EXPIRED;
            end
            else if (!fwd_ok_reg)
            begin
                res_action_next = mdff_pkg::ACT_DEFERRED;
            end
            else
            begin
                res_action_next = mdff_pkg::ACT_FORWARD;
                res_ttl_next    = ttl_reg - mdff_pkg::TTL_W'(1);
            end
        end

        if (out_load)
        begin
            out_valid_next  = 1'b1;
            out_action_next = res_action_reg;
            out_ttl_next    = res_ttl_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mdff_pkg::ST_IDLE;
            wp_reg        <= '0;
            valid_reg     <= '0;
            scan_cnt_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            valid_reg     <= valid_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_pend_reg   <= ram_re;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        src_reg        <= src_next;
        seq_reg        <= seq_next;
        ttl_reg        <= ttl_next;
        fwd_ok_reg     <= fwd_ok_next;
        own_reg        <= own_next;
        valid_q_reg    <= valid_reg[ram_raddr];
        res_action_reg <= res_action_next;
        res_ttl_reg    <= res_ttl_next;
        out_action_reg <= out_action_next;
        out_ttl_reg    <= out_ttl_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_ttl_reg;
    assign m_axis_tuser  = out_action_reg;

    // ---------------- assertions ----------------
    // one header at a time: after a beat is taken the input closes
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    // a nonzero new_ttl only comes with a forward verdict
    a_ttl_only_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tdata != '0)) |->
            (m_axis_tuser == mdff_pkg::ACT_FORWARD))
        else $error("new_ttl set on a non-forward verdict");

    // the ring is never written while it is being scanned
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> !ram_we)
        else $error("ring write during scan");

    // a record step always moves the write pointer
    a_wp_moves: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> (wp_reg != $past(wp_reg)))
        else $error("ring write pointer did not advance");

endmodule

[bench/tb_mesh_duplicate_filter_forwarder.sv]
// Self-checking testbench for the mesh duplicate filter and forwarder.
`timescale 1ns / 1ps

module tb_mesh_duplicate_filter_forwarder;

    localparam int SEEN_DEPTH  = 16;
    localparam int ITEMS_PHASE = 275;
    localparam int NUM_PHASES  = 6;
    localparam int SETTLE      = SEEN_DEPTH + 8;   // worst-case verdict latency plus margin
    localparam int HOLD_CYCLES = 300;
    localparam logic [2:0] MY_ID_ADDR = {mdff_pkg::REG_MY_ID, 2'b00};

    // one received header as the sender sees it
    typedef struct packed {
        logic [mdff_pkg::SRC_W-1:0] src;
        logic [mdff_pkg::SEQ_W-1:0] seq;
        logic [mdff_pkg::TTL_W-1:0] ttl;
        logic                       fwd_ok;
    } hdr_t;

    // one verdict beat
    typedef struct packed {
        mdff_pkg::action_t          act;
        logic [mdff_pkg::TTL_W-1:0] new_ttl;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;    // [7:0] src, [23:8] seq, [31:24] ttl
    logic        s_axis_tuser = 1'b0;  // [0] forward_allowed

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [7:0] new_ttl
    logic [2:0]  m_axis_tuser;         // [2:0] action

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mesh_duplicate_filter_forwarder #(
        .SEEN_DEPTH(SEEN_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: node id plus the ring of recently seen pairs.
    // Ring starts all zero, so (0,0) is already "seen" after reset.
    // ------------------------------------------------------------------
    logic [7:0]                 node_id = 8'h00;
    logic [mdff_pkg::SRC_W-1:0] seen_src [SEEN_DEPTH];
    logic [mdff_pkg::SEQ_W-1:0] seen_seq [SEEN_DEPTH];
    int                         ring_ptr = 0;

    hdr_t             pending_headers[$];
    verdict_t         expected_verdicts[$];
    logic [23:0]      recent_pairs[$];   // replay pool for duplicates and evictions

    int  mismatches = 0;
    bit  idle_on = 1'b1;     // random gaps on both sides
    bit  hold_go = 1'b0;     // kicks off the long receiver hold-off
    bit  hold_on = 1'b0;
    bit  beat_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;

    initial
    begin
        for (int i = 0; i < SEEN_DEPTH; i++)
        begin
            seen_src[i] = '0;
            seen_seq[i] = '0;
        end
    end

    function automatic void note_mismatch(string msg);
        if (mismatches < 10)
            $display("%s", msg);
        mismatches++;
    endfunction

    function automatic void log_pair(logic [mdff_pkg::SRC_W-1:0] s,
                                     logic [mdff_pkg::SEQ_W-1:0] q);
        seen_src[ring_ptr] = s;
        seen_seq[ring_ptr] = q;
        ring_ptr = (ring_ptr + 1) % SEEN_DEPTH;
    endfunction

    // Decision order: own id first (always recorded), then ring hit,
    // then record and grade by ttl, spacing flag, forward.
    function automatic verdict_t judge_header(hdr_t h);
        verdict_t v;
        bit       hit;
        v.act     = mdff_pkg::ACT_FORWARD;
        v.new_ttl = '0;
        hit       = 1'b0;
        if (h.src == node_id)
        begin
            log_pair(h.src, h.seq);
            v.act = mdff_pkg::ACT_OWN;
        end
        else
        begin
            for (int i = 0; i < SEEN_DEPTH; i++)
                if (seen_src[i] == h.src && seen_seq[i] == h.seq)
                    hit = 1'b1;
            if (hit)
            begin
                v.act = mdff_pkg::ACT_DUP;
            end
            else
            begin
                log_pair(h.src, h.seq);
                if (h.ttl == '0)
                    v.act = mdff_pkg::ACT_TTL_EXPIRED;
                else if (!h.fwd_ok)
                    v.act = mdff_pkg::ACT_DEFERRED;
                else
                    v.new_ttl = h.ttl - 1'b1;
            end
        end
        return v;
    endfunction

    // Mostly short gaps, now and then a long one; none when idling is off.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 4);
        else
            return $urandom_range(12, 60);
    endfunction

    function automatic void queue_header(logic [7:0] s, logic [15:0] q, logic [7:0] t,
                                         logic f);
        hdr_t h;
        h.src    = s;
        h.seq    = q;
        h.ttl    = t;
        h.fwd_ok = f;
        pending_headers.push_back(h);
    endfunction

    // Random header biased so the ring sees repeats: replays of recent
    // pairs (some still in the ring, some evicted), own-id traffic, a small
    // pool of neighbors with narrow sequence space, and fully random pairs.
    function automatic hdr_t make_header();
        hdr_t        h;
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        if (r < 25 && recent_pairs.size() > 0)
        begin
            k = $urandom_range(0, recent_pairs.size() - 1);
            {h.src, h.seq} = recent_pairs[k];
        end
        else if (r < 35)
        begin
            h.src = node_id;
            h.seq = 16'($urandom);
        end
        else if (r < 75)
        begin
            h.src = 8'($urandom_range(1, 4));
            h.seq = 16'($urandom_range(0, 15));
        end
        else
        begin
            h.src = 8'($urandom);
            h.seq = 16'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 15)
            h.ttl = 8'h00;
        else if (r < 20)
            h.ttl = 8'hFF;
        else if (r < 25)
            h.ttl = 8'h01;
        else
            h.ttl = 8'($urandom);
        h.fwd_ok = ($urandom_range(0, 99) < 70);
        recent_pairs.push_back({h.src, h.seq});
        if (recent_pairs.size() > 24)
            void'(recent_pairs.pop_front());
        return h;
    endfunction

    // ------------------------------------------------------------------
    // Header driver: new beat only once the current one was taken.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        hdr_t h;
        if (rst_n && (!s_axis_tvalid || beat_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_headers.size() != 0)
            begin
                h = pending_headers.pop_front();
                s_axis_tdata  <= {h.ttl, h.seq, h.src};
                s_axis_tuser  <= h.fwd_ok;
                s_axis_tvalid <= 1'b1;
                gap_left = pick_gap();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Verdict sink pacing; the hold-off wins over everything else.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic ready_next;
        ready_next = 1'b1;
        if (!rst_n)
        begin
            ready_next = 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (idle_on)
        begin
            stall_left = pick_gap();
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
        end
        if (hold_on)
            ready_next = 1'b0;
        m_axis_tready <= ready_next;
    end

    // Long hold-off, counted in its own process, while headers keep coming.
    initial
    begin
        @(posedge hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: check verdict beats, predict on every accepted header.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        verdict_t want;
        hdr_t     h;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected verdict: action %0d ttl %0d",
                                            m_axis_tuser, m_axis_tdata));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (m_axis_tuser !== want.act || m_axis_tdata !== want.new_ttl)
                        note_mismatch($sformatf(
                            "verdict mismatch: exp action %0d ttl %0d, got action %0d ttl %0d",
                            want.act, want.new_ttl, m_axis_tuser, m_axis_tdata));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                h.src    = s_axis_tdata[7:0];
                h.seq    = s_axis_tdata[23:8];
                h.ttl    = s_axis_tdata[31:24];
                h.fwd_ok = s_axis_tuser;
                expected_verdicts.push_back(judge_header(h));
            end
        end
        beat_taken <= s_axis_tvalid && s_axis_tready;
    end

    // APB write of my_id, then read it back.
    task automatic set_node_id(input logic [7:0] id);
        logic [31:0] back;
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= MY_ID_ADDR;
        pwdata  <= {24'b0, id};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        back = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        node_id = id;
        if (back !== {24'b0, id})
            note_mismatch($sformatf("my_id readback: exp %0h, got %0h", id, back));
    endtask

    // Wait until every header is in and every verdict is out, then settle.
    task automatic drain();
        while (pending_headers.size() != 0 || s_axis_tvalid ||
               expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset, directed headers, then random phases with
    // different node ids (both extremes among them).
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] id_plan [NUM_PHASES];
        id_plan = '{8'h00, 8'hFF, 8'h01, 8'($urandom), 8'h80, 8'($urandom)};

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_node_id(8'h5A);
        @(posedge clk);
        queue_header(8'h00, 16'h0000, 8'd5,   1'b1);  // (0,0) seen straight after reset
        queue_header(8'h5A, 16'h1234, 8'd9,   1'b1);  // own packet
        queue_header(8'h5A, 16'h1234, 8'd9,   1'b1);  // own again, already in ring
        queue_header(8'h01, 16'h0001, 8'd0,   1'b1);  // ttl zero
        queue_header(8'h01, 16'h0001, 8'd7,   1'b1);  // duplicate of an expired one
        queue_header(8'h02, 16'h0002, 8'd3,   1'b0);  // spacing not met
        queue_header(8'h02, 16'h0002, 8'd3,   1'b1);  // deferred pair stays recorded
        queue_header(8'hFF, 16'hFFFF, 8'hFF,  1'b1);  // forward, all-ones fields
        queue_header(8'h03, 16'h8000, 8'd1,   1'b1);  // forward with ttl down to zero
        queue_header(8'h80, 16'h00FF, 8'h80,  1'b0);  // deferred
        queue_header(8'h00, 16'hFFFF, 8'h00,  1'b0);  // ttl zero wins over spacing
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_node_id(id_plan[ph]);
            @(posedge clk);
            idle_on = (ph != 2);   // one phase runs back to back
            if (id_plan[ph] == 8'h00)
                queue_header(8'h00, 16'h0000, 8'd4, 1'b1);  // own id beats the seen check
            for (int n = 0; n < ITEMS_PHASE; n++)
                pending_headers.push_back(make_header());
            if (ph == 3)
                hold_go = 1'b1;
            drain();
        end

        if (expected_verdicts.size() != 0)
            note_mismatch($sformatf("%0d verdicts never arrived", expected_verdicts.size()));
        if (mismatches == 0)
            $display("mesh_duplicate_filter_forwarder regression: pass");
        else
            $display("mesh_duplicate_filter_forwarder regression: fail");
        $finish;
    end

    // Watchdog, well above the slowest legal run.
    initial
    begin
        #12_000_000;
        $display("mesh_duplicate_filter_forwarder regression: fail");
        $finish;
    end

endmodule

[sim.f]
rtl/mdff_pkg.sv
rtl/mdff_ram.sv
rtl/mesh_duplicate_filter_forwarder.sv
bench/tb_mesh_duplicate_filter_forwarder.sv
